// File: hdl/orbit_camera_position_unit_assert.svh
// Assertion macros shared by the orbit camera checker.
`ifndef ORBIT_CAMERA_POSITION_UNIT_ASSERT_SVH
`define ORBIT_CAMERA_POSITION_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("orbit camera check failed");
// Next-cycle implication checked on every clock edge outside reset.
`define OCP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("orbit camera check failed");
`endif

// File: hdl/ocp_pkg.sv
// Package with constants and tables of the orbit camera unit.
`default_nettype none
package ocp_pkg;
  localparam int ANGLE_BITS_DEF = 32;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int TRIG_BITS_DEF = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 5;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] PITCH_MAX_P32 = 32'd956991386;
  localparam logic [31:0] PITCH_MIN_P32 = 32'd273426110;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORBIT_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_HEIGHT = 2'd2;
  localparam logic [23:0] ROT_SPEED_RST = 24'd3417826;
  localparam logic [30:0] ORBIT_DIST_RST = 31'd327680;
  localparam logic [31:0] LOOK_HEIGHT_RST = 32'd98304;

  function automatic logic [29:0] atan_phase(input logic [STEP_W-1:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0: r = 30'd536870912;  5'd1: r = 30'd316933406;
      5'd2: r = 30'd167458907;  5'd3: r = 30'd85004757;
      5'd4: r = 30'd42667331;   5'd5: r = 30'd21354465;
      5'd6: r = 30'd10679838;   5'd7: r = 30'd5340245;
      5'd8: r = 30'd2670163;    5'd9: r = 30'd1335087;
      5'd10: r = 30'd667544;    5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;    5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;     5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;     5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;       5'd21: r = 30'd326;
      5'd22: r = 30'd163;       5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: hdl/ocp_if.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none
interface ocp_in_if;
  logic               valid;
  logic               ready;
  logic               drag_active;
  logic signed [15:0] mouse_dx;
  logic signed [15:0] mouse_dy;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  modport source (output valid, drag_active, mouse_dx, mouse_dy, target_x, target_y,
                  target_z, input ready);
  modport sink (input valid, drag_active, mouse_dx, mouse_dy, target_x, target_y,
                target_z, output ready);
endinterface

interface ocp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cam_x;
  logic signed [31:0] cam_y;
  logic signed [31:0] cam_z;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;
  modport source (output valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
                  input ready);
  modport sink (input valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
                output ready);
endinterface
`default_nettype wire

// File: hdl/orbit_camera_position_unit.sv
// Top level of the orbit camera unit: angle update, shared CORDIC and multiplier.
// A result word is produced after its input word is taken by the angle update, two CORDIC runs
// (load, 24 micro-rotations, fold each), the back vector and distance products and the final sums.
// Only one word is in flight: a new input word is taken only once the result word has been
// taken on out_ready. The single CORDIC stage and 34x32 multiplier serve every step.
// Synchronous active-low reset clears angles and the sequencer.
`default_nettype none
module orbit_camera_position_unit #(
  parameter int ANGLE_BITS      = ocp_pkg::ANGLE_BITS_DEF,
  parameter int COORD_FRAC_BITS = ocp_pkg::COORD_FRAC_BITS_DEF,
  parameter int TRIG_BITS       = ocp_pkg::TRIG_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ocp_in_if.sink                              in_ch,
  ocp_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ocp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import ocp_pkg::*;

  // Coordinates share one format, so the fraction width never enters the datapath.
  localparam int TSH  = 31 - TRIG_BITS;          // CORDIC output rounding shift
  localparam int PSH  = TRIG_BITS - 1;           // product rounding shift
  localparam int ASH  = 32 - ANGLE_BITS;
  localparam logic signed [TRIG_BITS-1:0] TMAX = {1'b0, {(TRIG_BITS-1){1'b1}}};
  localparam logic signed [TRIG_BITS-1:0] TMIN = {1'b1, {(TRIG_BITS-1){1'b0}}};

  // The sequencer runs the angle update, loads each rotation, steps it, folds and
  // stores it, then works through the back vector and distance products and the final sums.
  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_CLAMP, S_LOAD, S_CRD, S_CFIN, S_BX, S_BZ, S_MX, S_MY, S_MZ,
    S_SUM, S_OUT
  } state_t;

  state_t state_r;
  logic [23:0] rot_speed_r;
  logic [30:0] orbit_dist_r;
  logic signed [31:0] look_height_r;
  logic [ANGLE_BITS-1:0] yaw_r, pitch_r;

  logic drag_r;
  logic signed [15:0] dx_r, dy_r;
  logic signed [31:0] tx_r, ty_r, tz_r;
  logic signed [40:0] yaw_sum_r;
  logic signed [40:0] pitch_sum;

  // CORDIC working registers; x/y stay within 34 bits signed.
  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic [1:0] quad_r;
  logic [STEP_W-1:0] step_r;
  logic which_r;                                 // 0 yaw, 1 pitch
  logic signed [TRIG_BITS-1:0] sy_r, cy_tr, sp_r, cp_r, bx_r, bz_r;
  logic signed [33:0] ox_r, oy_r, oz_r;
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r, look_y_r;

  // Shared multiplier: 34-bit signed by 32-bit signed.
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_UPD: begin
        mul_a = 34'(dx_r);
        mul_b = $signed({8'd0, rot_speed_r});
      end
      S_CLAMP: begin
        mul_a = 34'(dy_r);
        mul_b = $signed({8'd0, rot_speed_r});
      end
      S_BX: begin mul_a = -34'(sy_r); mul_b = 32'(cp_r); end
      S_BZ: begin mul_a = -34'(cy_tr); mul_b = 32'(cp_r); end
      S_MX: begin mul_a = 34'(bx_r); mul_b = $signed({1'b0, orbit_dist_r}); end
      S_MY: begin mul_a = 34'(sp_r); mul_b = $signed({1'b0, orbit_dist_r}); end
      S_MZ: begin mul_a = 34'(bz_r); mul_b = $signed({1'b0, orbit_dist_r}); end
      default: ;
    endcase
    mul_p = 66'(mul_a) * 66'(mul_b);
  end

  function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
    return (v + (66'sd1 <<< s)/2) >>> s;
  endfunction

  function automatic logic signed [TRIG_BITS-1:0] tsat(input logic signed [65:0] v);
    logic signed [TRIG_BITS-1:0] r;
    if (v > 66'(TMAX)) r = TMAX;
    else if (v < 66'(TMIN)) r = TMIN;
    else r = v[TRIG_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7fffffff;
    else if (v < -34'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Current CORDIC input phase.
  logic [31:0] phase32;
  assign phase32 = which_r ? 32'(pitch_r) << ASH : 32'(yaw_r) << ASH;

  // Pitch limits in the native angle width, sign extended.
  localparam logic signed [40:0] PMAX = 41'($signed({1'b0, PITCH_MAX_P32}) >>> ASH);
  localparam logic signed [40:0] PMIN = -41'($signed({1'b0, PITCH_MIN_P32}) >>> ASH);

  // Pitch after the mouse step, before the clamp.
  assign pitch_sum = 41'($signed(pitch_r)) + 41'(mul_p);

  // CORDIC final rounding and quadrant fold.
  logic signed [TRIG_BITS-1:0] c_fin, s_fin, cs_q, sn_q;
  always_comb begin
    c_fin = tsat(rnd(66'(cx_r), TSH));
    s_fin = tsat(rnd(66'(cy_r), TSH));
    unique case (quad_r)
      2'd0: begin cs_q = c_fin; sn_q = s_fin; end
      2'd1: begin cs_q = tsat(-66'(s_fin)); sn_q = c_fin; end
      2'd2: begin cs_q = tsat(-66'(c_fin)); sn_q = tsat(-66'(s_fin)); end
      default: begin cs_q = s_fin; sn_q = tsat(-66'(c_fin)); end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.cam_x = cam_x_r;
  assign out_ch.cam_y = cam_y_r;
  assign out_ch.cam_z = cam_z_r;
  assign out_ch.look_x = tx_r;
  assign out_ch.look_y = look_y_r;
  assign out_ch.look_z = tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rot_speed_r <= ROT_SPEED_RST;
      orbit_dist_r <= ORBIT_DIST_RST;
      look_height_r <= LOOK_HEIGHT_RST;
      yaw_r <= '0;
      pitch_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROT_SPEED:   rot_speed_r <= cfg_data[23:0];
          REG_ORBIT_DIST:  orbit_dist_r <= cfg_data[30:0];
          REG_LOOK_HEIGHT: look_height_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_ch.valid) begin
          drag_r <= in_ch.drag_active;
          dx_r <= in_ch.mouse_dx;
          dy_r <= in_ch.mouse_dy;
          tx_r <= in_ch.target_x;
          ty_r <= in_ch.target_y;
          tz_r <= in_ch.target_z;
          state_r <= S_UPD;
        end
        S_UPD: begin
          yaw_sum_r <= 41'(mul_p);
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          if (drag_r) begin
            yaw_r <= yaw_r + ANGLE_BITS'(yaw_sum_r);
            if (pitch_sum > PMAX) pitch_r <= ANGLE_BITS'(PMAX);
            else if (pitch_sum < PMIN) pitch_r <= ANGLE_BITS'(PMIN);
            else pitch_r <= ANGLE_BITS'(pitch_sum);
          end
          which_r <= 1'b0;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          cx_r <= CORDIC_GAIN_Q30;
          cy_r <= '0;
          cz_r <= $signed({2'b00, phase32[29:0]});
          quad_r <= phase32[31:30];
          step_r <= '0;
          state_r <= S_CRD;
        end
        S_CRD: begin
          if (!cz_r[31]) begin
            cx_r <= cx_r - (cy_r >>> step_r);
            cy_r <= cy_r + (cx_r >>> step_r);
            cz_r <= cz_r - $signed({2'b00, atan_phase(step_r)});
          end else begin
            cx_r <= cx_r + (cy_r >>> step_r);
            cy_r <= cy_r - (cx_r >>> step_r);
            cz_r <= cz_r + $signed({2'b00, atan_phase(step_r)});
          end
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_r <= S_CFIN;
        end
        S_CFIN: begin
          // The yaw rotation is stored and the pitch one loaded next; after the
          // pitch rotation the products follow.
          if (!which_r) begin
            sy_r <= sn_q;
            cy_tr <= cs_q;
            which_r <= 1'b1;
            state_r <= S_LOAD;
          end else begin
            sp_r <= sn_q;
            cp_r <= cs_q;
            state_r <= S_BX;
          end
        end
        S_BX: begin bx_r <= tsat(rnd(mul_p, PSH)); state_r <= S_BZ; end
        S_BZ: begin bz_r <= tsat(rnd(mul_p, PSH)); state_r <= S_MX; end
        S_MX: begin ox_r <= 34'(rnd(mul_p, PSH)); state_r <= S_MY; end
        S_MY: begin oy_r <= 34'(rnd(mul_p, PSH)); state_r <= S_MZ; end
        S_MZ: begin oz_r <= 34'(rnd(mul_p, PSH)); state_r <= S_SUM; end
        S_SUM: begin
          cam_x_r <= sat32(34'(tx_r) + ox_r);
          cam_y_r <= sat32(34'(ty_r) + 34'(look_height_r) + oy_r);
          cam_z_r <= sat32(34'(tz_r) + oz_r);
          look_y_r <= sat32(34'(ty_r) + 34'(look_height_r));
          state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/ocp_checker.sv
// Port-level checker for the orbit camera unit, bound to the top level.
`default_nettype none
`include "orbit_camera_position_unit_assert.svh"
module ocp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  `OCP_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `OCP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `OCP_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
endmodule
bind orbit_camera_position_unit ocp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready));
`default_nettype wire
